### rtl/csrnap_pkg.sv
package csrnap_pkg;

  // Width of a resolved register address.
  localparam int ADDR_BITS = 12;
  // Number of slots in the name table; the last slot is empty.
  localparam int NAME_COUNT = 33;
  // Storage per name, terminator included.
  localparam int NAME_SLOT = 11;
  // Length of the performance counter prefix.
  localparam int PREFIX_LEN = 11;
  // Widest value that the decimal counter index holds.
  localparam int CNT_MAX = 63;
  localparam int CNT_LOW = 3;
  localparam int CNT_HIGH = 31;

  localparam logic [ADDR_BITS-1:0] CNT_BASE_LO = 12'hB00;
  localparam logic [ADDR_BITS-1:0] CNT_BASE_HI = 12'hB80;

  // Characters that steer the parse.
  localparam logic [7:0] CHAR_ZERO = "0";
  localparam logic [7:0] CHAR_NINE = "9";
  localparam logic [7:0] CHAR_LX = "x";
  localparam logic [7:0] CHAR_UX = "X";
  localparam logic [7:0] CHAR_LA = "a";
  localparam logic [7:0] CHAR_LF = "f";
  localparam logic [7:0] CHAR_UA = "A";
  localparam logic [7:0] CHAR_UF = "F";
  localparam logic [7:0] CHAR_LH = "h";

  // Parse state for the name being received.
  typedef enum logic [1:0] {
    MODE_OPEN = 2'd0,
    MODE_HEX  = 2'd1,
    MODE_CNT  = 2'd2,
    MODE_TAB  = 2'd3
  } parse_mode_e;

  // Name table: the text right-justified, its length and its address.
  localparam logic [79:0] NAME_TEXT [NAME_COUNT] = '{
    "fflags", "frm", "fcsr",
    "cycle", "time", "instret",
    "cycleh", "timeh", "instreth",
    "mvendorid", "marchid", "mimpid",
    "mhartid",
    "mstatus", "misa", "medeleg",
    "mideleg", "mie", "mtvec",
    "mcounteren", "mscratch", "mepc",
    "mcause", "mtval", "mip",
    "mcycle", "minstret",
    "mcycleh", "minstreth",
    "pmpcfg0", "pmpaddr0",
    "satp",
    80'd0
  };

  localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
    4'd6, 4'd3, 4'd4,
    4'd5, 4'd4, 4'd7,
    4'd6, 4'd5, 4'd8,
    4'd9, 4'd7, 4'd6,
    4'd7,
    4'd7, 4'd4, 4'd7,
    4'd7, 4'd3, 4'd5,
    4'd10, 4'd8, 4'd4,
    4'd6, 4'd5, 4'd3,
    4'd6, 4'd8,
    4'd7, 4'd9,
    4'd7, 4'd8,
    4'd4,
    4'd0
  };

  localparam logic [ADDR_BITS-1:0] NAME_ADDR [NAME_COUNT] = '{
    12'h001, 12'h002, 12'h003,
    12'hC00, 12'hC01, 12'hC02,
    12'hC80, 12'hC81, 12'hC82,
    12'hF11, 12'hF12, 12'hF13,
    12'hF14,
    12'h300, 12'h301, 12'h302,
    12'h303, 12'h304, 12'h305,
    12'h306, 12'h340, 12'h341,
    12'h342, 12'h343, 12'h344,
    12'hB00, 12'hB02,
    12'hB80, 12'hB82,
    12'h3A0, 12'h3B0,
    12'h180,
    12'h000
  };

  localparam logic [87:0] PREFIX_TEXT = "mhpmcounter";

  // Character at position pos of table entry idx; zero past its end.
  function automatic logic [7:0] name_char(input int unsigned idx, input logic [3:0] pos);
    int unsigned len;
    int unsigned sh;
    len = int'(NAME_LEN[idx]);
    sh = 0;
    if (int'(pos) < len) begin
      sh = 8 * (len - 1 - int'(pos));
      return NAME_TEXT[idx][sh +: 8];
    end
    return 8'd0;
  endfunction

  // Character at position pos of the counter prefix.
  function automatic logic [7:0] prefix_char(input logic [3:0] pos);
    int unsigned sh;
    sh = 0;
    if (int'(pos) < PREFIX_LEN) begin
      sh = 8 * (PREFIX_LEN - 1 - int'(pos));
      return PREFIX_TEXT[sh +: 8];
    end
    return 8'd0;
  endfunction

endpackage

### rtl/csr_name_to_address_parser.sv
// Register name decoder: one character word per cycle while in_stall_o is low,
// one result word per name. The result is registered and appears in the cycle
// after the last character is accepted. The name table is compared in parallel
// and the state registers take each character in the cycle it arrives.
// Reset: asynchronous and active low; it clears the parse state and the result
// register, ready for the first character of a name.
module csr_name_to_address_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         character_i,
  input  logic                               last_char_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [csrnap_pkg::ADDR_BITS-1:0]   csr_address_o,
  output logic                               found_o
);
  import csrnap_pkg::*;

  logic [3:0]            pos_q, pos_d;
  parse_mode_e           mode_q, mode_d;
  logic [ADDR_BITS-1:0]  hex_q, hex_d;
  logic                  ovf_q, ovf_d;
  logic [5:0]            cnt_q, cnt_d;
  logic                  hsuf_q, hsuf_d;
  logic                  err_q, err_d;
  logic [NAME_COUNT-1:0] mask_q, mask_d;
  logic [NAME_COUNT-1:0] keep;

  logic                  out_valid_q;
  logic [ADDR_BITS-1:0]  addr_q, addr_d;
  logic                  found_q, found_d;

  logic                  in_acc;
  logic                  is_dec;
  logic                  hex_ok;
  logic [3:0]            hex_nib;
  logic [9:0]            cnt_sum;

  // A new word is held off only while a finished result is stalled.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc = in_valid_i & ~in_stall_o;

  // Classify the incoming character as a decimal or hexadecimal digit.
  always_comb begin
    is_dec = (character_i >= CHAR_ZERO) && (character_i <= CHAR_NINE);
    hex_ok = 1'b1;
    hex_nib = 4'd0;
    if (is_dec) begin
      hex_nib = 4'(character_i - CHAR_ZERO);
    end else if ((character_i >= CHAR_LA) && (character_i <= CHAR_LF)) begin
      hex_nib = 4'(character_i - CHAR_LA + 8'd10);
    end else if ((character_i >= CHAR_UA) && (character_i <= CHAR_UF)) begin
      hex_nib = 4'(character_i - CHAR_UA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
    cnt_sum = 10'(cnt_q) * 10'd10 + 10'(hex_nib);
  end

  // Table entries that still agree with the name after this character.
  always_comb begin
    for (int k = 0; k < NAME_COUNT; k++) begin
      keep[k] = (int'(pos_q) < NAME_SLOT - 1) && (name_char(k, pos_q) != 8'd0) &&
                (name_char(k, pos_q) == character_i);
    end
  end

  // Parse step and result on the last character.
  always_comb begin
    pos_d = pos_q;
    mode_d = mode_q;
    hex_d = hex_q;
    ovf_d = ovf_q;
    cnt_d = cnt_q;
    hsuf_d = hsuf_q;
    err_d = err_q;
    mask_d = mask_q;
    addr_d = addr_q;
    found_d = found_q;
    if (in_acc) begin
      case (mode_q)
        MODE_OPEN: begin
          if ((pos_q == 4'd0) && (character_i == CHAR_ZERO)) begin
            mode_d = MODE_HEX;
          end else begin
            mask_d = mask_q & keep;
            if ((int'(pos_q) < PREFIX_LEN) && (character_i == prefix_char(pos_q))) begin
              if (int'(pos_q) == PREFIX_LEN - 1) begin
                mode_d = MODE_CNT;
              end
            end else begin
              mode_d = MODE_TAB;
            end
          end
        end
        MODE_HEX: begin
          if (pos_q == 4'd1) begin
            if ((character_i != CHAR_LX) && (character_i != CHAR_UX)) begin
              err_d = 1'b1;
            end
          end else if (!hex_ok) begin
            err_d = 1'b1;
          end else begin
            if (hex_q[ADDR_BITS-1 -: 4] != 4'd0) begin
              ovf_d = 1'b1;
            end
            hex_d = {hex_q[ADDR_BITS-5:0], hex_nib};
          end
        end
        MODE_CNT: begin
          if (hsuf_q) begin
            err_d = 1'b1;
          end else if (is_dec) begin
            cnt_d = (cnt_sum > 10'(CNT_MAX)) ? 6'(CNT_MAX) : cnt_sum[5:0];
          end else if (character_i == CHAR_LH) begin
            hsuf_d = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
        default: begin
          mask_d = mask_q & keep;
        end
      endcase

      if (!last_char_i) begin
        if (pos_q != 4'hF) begin
          pos_d = pos_q + 4'd1;
        end
      end else begin
        addr_d = '0;
        found_d = 1'b0;
        if (mode_d == MODE_HEX) begin
          if ((pos_q != 4'd0) && !err_d && !ovf_d) begin
            found_d = 1'b1;
            addr_d = hex_d;
          end
        end else if (mode_d == MODE_CNT) begin
          if (!err_d && (int'(cnt_d) >= CNT_LOW) && (int'(cnt_d) <= CNT_HIGH)) begin
            found_d = 1'b1;
            addr_d = (hsuf_d ? CNT_BASE_HI : CNT_BASE_LO) + ADDR_BITS'(cnt_d);
          end
        end else if (int'(pos_q) + 1 < NAME_SLOT) begin
          // Lowest matching slot wins, so scan from the top down.
          for (int k = NAME_COUNT - 1; k >= 0; k--) begin
            if (mask_d[k] && (NAME_LEN[k] == pos_q + 4'd1)) begin
              found_d = 1'b1;
              addr_d = NAME_ADDR[k];
            end
          end
        end
        // Clear the parse state for the next name.
        pos_d = 4'd0;
        mode_d = MODE_OPEN;
        hex_d = '0;
        ovf_d = 1'b0;
        cnt_d = 6'd0;
        hsuf_d = 1'b0;
        err_d = 1'b0;
        mask_d = '1;
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
      mode_q <= MODE_OPEN;
      hex_q <= '0;
      ovf_q <= 1'b0;
      cnt_q <= 6'd0;
      hsuf_q <= 1'b0;
      err_q <= 1'b0;
      mask_q <= '1;
    end else begin
      pos_q <= pos_d;
      mode_q <= mode_d;
      hex_q <= hex_d;
      ovf_q <= ovf_d;
      cnt_q <= cnt_d;
      hsuf_q <= hsuf_d;
      err_q <= err_d;
      mask_q <= mask_d;
    end
  end

  // Result register; it empties when the downstream side takes the word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && last_char_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      found_q <= 1'b0;
    end else begin
      addr_q <= addr_d;
      found_q <= found_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign csr_address_o = addr_q;
  assign found_o = found_q;

endmodule
